@@ hdl/mcf_pkg.sv @@
// Shared constants and types for the multichannel comb filter.
package mcf_pkg;

    localparam int DELAY_DEPTH  = 65536;
    localparam int MAX_CHANNELS = 2;

    localparam int DELAY_AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int MEM_DEPTH = MAX_CHANNELS * DELAY_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CH_IW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CALC_W    = ((DELAY_AW > 16) ? DELAY_AW : 16) + 1;
    localparam int CNT_W     = 6;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IW   = 8;
    localparam int CFG_DW   = 16;

    localparam logic [CFG_IW-1:0] REG_FILTER_MODE     = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_GAIN            = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_DELAY_SAMPLES   = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_ACTIVE_CHANNELS = CFG_IW'(3);

    localparam logic MODE_FEEDFORWARD = 1'b0;
    localparam logic MODE_FEEDBACK    = 1'b1;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic              blank;
    } mcf_rd_req_t;

    typedef struct packed {
        logic                       en;
        logic [MEM_AW-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } mcf_wr_req_t;

endpackage

@@ hdl/mcf_delay_mem.sv @@
// Delay line memory with registered read, bypass of the last write and blank-entry masking.
module mcf_delay_mem
    import mcf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcf_rd_req_t                rd_req,
    input  mcf_wr_req_t                wr_req,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];

    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [MEM_AW-1:0]          rd_addr_reg;
    logic                       rd_blank_reg;
    logic                       fwd_valid_reg;
    logic [MEM_AW-1:0]          fwd_addr_reg;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            rd_data_reg  <= mem[rd_req.addr];
            rd_addr_reg  <= rd_req.addr;
            rd_blank_reg <= rd_req.blank;
        end
        if (wr_req.en)
        begin
            fwd_addr_reg <= wr_req.addr;
            fwd_data_reg <= wr_req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_req.en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_blank_reg)
        begin
            rd_data = '0;
        end
        else
        begin
            rd_data = rd_data_reg;
        end
    end

endmodule

@@ hdl/multichannel_comb_filter.sv @@
// Top level of the multichannel comb filter: config, address stage, filter stage, output word.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | sample_in, channel, end_of_block
//  out     | output    | out_valid / out_stall | sample_out, out_channel, out_end_of_block
//  cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One word per cycle unless out_stall holds it; words pass the stage 1 and output registers.
// Stage 0 forms the delay address and reads the memory; stage 1 multiplies, adds,
// saturates and writes back; the last write is bypassed to cover a delay of one.
// Reset sets config defaults and clears write pointers and fill flags; unwritten entries
// read as zero. out_stall holds the output word and backs up into in_stall through the stages.
module multichannel_comb_filter
    import mcf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       channel,
    input  logic                       end_of_block,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       out_channel,
    output logic                       out_end_of_block,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IW-1:0]          cfg_index,
    input  logic [CFG_DW-1:0]          cfg_data
);

    logic                       filter_mode_reg;
    logic signed [15:0]         gain_reg;
    logic [15:0]                delay_samples_reg;
    logic [1:0]                 active_channels_reg;

    logic [DELAY_AW-1:0]        wp_reg [MAX_CHANNELS];
    logic                       wrapped_reg [MAX_CHANNELS];

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_ch_reg;
    logic                       s1_eob_reg;
    logic                       s1_active_reg;
    logic [MEM_AW-1:0]          s1_waddr_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_ch_reg;
    logic                       out_eob_reg;

    logic                       out_free;
    logic                       s1_move;
    logic                       accept;
    logic [CH_IW-1:0]           ch_idx;
    logic [CNT_W-1:0]           nch;
    logic                       ch_active;
    logic [CALC_W-1:0]          d_ext;
    logic [CALC_W-1:0]          d_eff;
    logic [DELAY_AW-1:0]        wp_cur;
    logic [CALC_W-1:0]          wp_ext;
    logic [CALC_W-1:0]          rp_ext;
    logic [DELAY_AW-1:0]        rp;
    logic [DELAY_AW-1:0]        wp_next;
    logic [MEM_AW-1:0]          ch_base;
    mcf_rd_req_t                rd_req;
    mcf_wr_req_t                wr_req;
    logic signed [SAMPLE_W-1:0] past;
    logic signed [31:0]         prod;
    logic signed [32:0]         prod_rnd;
    logic signed [18:0]         scaled;
    logic signed [19:0]         sum;
    logic signed [SAMPLE_W-1:0] y;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg     <= MODE_FEEDFORWARD;
            gain_reg            <= 16'sd16384;
            delay_samples_reg   <= 16'd1;
            active_channels_reg <= 2'd2;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:     filter_mode_reg     <= cfg_data[0];
                REG_GAIN:            gain_reg            <= $signed(cfg_data[15:0]);
                REG_DELAY_SAMPLES:   delay_samples_reg   <= cfg_data[15:0];
                REG_ACTIVE_CHANNELS: active_channels_reg <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // stage 0: address
    assign ch_idx = CH_IW'(channel);

    always_comb
    begin
        priority if (active_channels_reg == 2'd0)
        begin
            nch = CNT_W'(1);
        end
        else if (CNT_W'(active_channels_reg) > CNT_W'(MAX_CHANNELS))
        begin
            nch = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            nch = CNT_W'(active_channels_reg);
        end
    end

    assign ch_active = CNT_W'(channel) < nch;

    assign d_ext = CALC_W'(delay_samples_reg);

    always_comb
    begin
        priority if (d_ext == '0)
        begin
            d_eff = CALC_W'(1);
        end
        else if (d_ext > CALC_W'(DELAY_DEPTH - 1))
        begin
            d_eff = CALC_W'(DELAY_DEPTH - 1);
        end
        else
        begin
            d_eff = d_ext;
        end
    end

    assign wp_cur = wp_reg[ch_idx];
    assign wp_ext = CALC_W'(wp_cur);
    assign rp_ext = (wp_ext >= d_eff) ? (wp_ext - d_eff)
                                      : (wp_ext + CALC_W'(DELAY_DEPTH) - d_eff);
    assign rp      = rp_ext[DELAY_AW-1:0];
    assign wp_next = (wp_ext == CALC_W'(DELAY_DEPTH - 1)) ? '0 : (wp_cur + 1'b1);
    assign ch_base = channel ? MEM_AW'(DELAY_DEPTH) : '0;

    always_comb
    begin
        rd_req.en    = accept && ch_active;
        rd_req.addr  = ch_base + MEM_AW'(rp);
        rd_req.blank = !wrapped_reg[ch_idx] && (rp >= wp_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                wp_reg[i]      <= '0;
                wrapped_reg[i] <= 1'b0;
            end
        end
        else if (accept && ch_active)
        begin
            wp_reg[ch_idx] <= wp_next;
            if (wp_ext == CALC_W'(DELAY_DEPTH - 1))
            begin
                wrapped_reg[ch_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in;
            s1_ch_reg     <= channel;
            s1_eob_reg    <= end_of_block;
            s1_active_reg <= ch_active;
            s1_waddr_reg  <= ch_base + MEM_AW'(wp_cur);
        end
        if (s1_move)
        begin
            out_sample_reg <= y;
            out_ch_reg     <= s1_ch_reg;
            out_eob_reg    <= s1_eob_reg;
        end
    end

    // stage 1: filter
    mcf_delay_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (past)
    );

    assign prod     = gain_reg * past;
    assign prod_rnd = 33'(prod) + 33'sd8192;
    assign scaled   = prod_rnd[32:14];
    assign sum      = 20'(s1_sample_reg) + 20'(scaled);

    always_comb
    begin
        priority if (!s1_active_reg)
        begin
            y = s1_sample_reg;
        end
        else if (sum > 20'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (sum < -20'sd32768)
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = sum[15:0];
        end
    end

    always_comb
    begin
        wr_req.en   = s1_move && s1_active_reg;
        wr_req.addr = s1_waddr_reg;
        wr_req.data = (filter_mode_reg == MODE_FEEDBACK) ? y : s1_sample_reg;
    end

    assign out_valid        = out_valid_reg;
    assign sample_out       = out_sample_reg;
    assign out_channel      = out_ch_reg;
    assign out_end_of_block = out_eob_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word not in filter stage");

    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) |=> $stable(wp_reg[0]))
        else $error("write pointer moved without an accepted word");

    a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |=> out_valid_reg)
        else $error("memory write without an output word");

endmodule

@@ tb/sv/mcf_comb_checker.sv @@
// Checker for the multichannel comb filter: tracks config writes, predicts each output word and compares.
module mcf_comb_checker
    import mcf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       channel,
    input  logic                       end_of_block,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       out_channel,
    input  logic                       out_end_of_block,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IW-1:0]          cfg_index,
    input  logic [CFG_DW-1:0]          cfg_data,
    output int                         mismatches,
    output int                         words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 32767;
    localparam longint SAT_LO = -32768;
    localparam longint ROUND_HALF = 8192;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       chan;
        logic                       eob;
    } comb_word_t;

    logic signed [SAMPLE_W-1:0] history [MAX_CHANNELS][DELAY_DEPTH];
    logic [DELAY_AW-1:0]        head [MAX_CHANNELS];
    logic                       mode;
    logic signed [CFG_DW-1:0]   gain_q14;
    logic [CFG_DW-1:0]          delay_len;
    logic [1:0]                 chan_count;
    comb_word_t                 filtered_words[$];
    int                         err_total;

    function automatic comb_word_t comb_predict(logic signed [SAMPLE_W-1:0] x, logic ch,
                                                logic eob);
        comb_word_t w;
        logic [1:0] n_eff;
        logic [CFG_DW-1:0] lag;
        logic [DELAY_AW-1:0] rd;
        longint prod;
        longint total;
        w.sample = x;
        w.chan = ch;
        w.eob = eob;
        n_eff = chan_count;
        if (n_eff < 1) n_eff = 1;
        if (n_eff > MAX_CHANNELS) n_eff = MAX_CHANNELS;
        if (ch < n_eff) begin
            lag = (delay_len == 0) ? CFG_DW'(1) : delay_len;
            if (lag > DELAY_DEPTH - 1) lag = CFG_DW'(DELAY_DEPTH - 1);
            rd = head[ch] - DELAY_AW'(lag);
            prod = longint'(gain_q14) * longint'(history[ch][rd]) + ROUND_HALF;
            total = longint'(x) + (prod >>> 14);
            if (total > SAT_HI) total = SAT_HI;
            else if (total < SAT_LO) total = SAT_LO;
            w.sample = SAMPLE_W'(total);
            history[ch][head[ch]] = (mode == MODE_FEEDBACK) ? w.sample : x;
            head[ch] = head[ch] + 1'b1;
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        comb_word_t got;
        comb_word_t want;
        if (!rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                head[c] = '0;
                for (int i = 0; i < DELAY_DEPTH; i++) history[c][i] = '0;
            end
            mode = MODE_FEEDFORWARD;
            gain_q14 = 16'sd16384;
            delay_len = CFG_DW'(1);
            chan_count = 2'd2;
            filtered_words.delete();
            err_total = 0;
            mismatches <= 0;
            words_in_flight <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                got.sample = sample_out;
                got.chan = out_channel;
                got.eob = out_end_of_block;
                if (filtered_words.size() == 0) begin
                    if (err_total < 10)
                        $display("%0t: output word with none expected: sample %0d ch %0d eob %0d",
                                 $realtime, got.sample, got.chan, got.eob);
                    err_total++;
                end else begin
                    want = filtered_words.pop_front();
                    if (got !== want) begin
                        if (err_total < 10)
                            $display({"%0t: mismatch: expected sample %0d ch %0d eob %0d, ",
                                      "got sample %0d ch %0d eob %0d"}, $realtime,
                                     want.sample, want.chan, want.eob,
                                     got.sample, got.chan, got.eob);
                        err_total++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FILTER_MODE:     mode = cfg_data[0];
                    REG_GAIN:            gain_q14 = cfg_data;
                    REG_DELAY_SAMPLES:   delay_len = cfg_data;
                    REG_ACTIVE_CHANNELS: chan_count = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                filtered_words.push_back(comb_predict(sample_in, channel, end_of_block));
            mismatches <= err_total;
            words_in_flight <= filtered_words.size();
        end
    end

endmodule

@@ tb/sv/tb_multichannel_comb_filter.sv @@
// Testbench top for the multichannel comb filter: drives words and config, gives the verdict.
module tb_multichannel_comb_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import mcf_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 14;
    localparam int WORDS_PER_PHASE = 100;
    localparam logic [CFG_IW-1:0] REG_FIRST_UNUSED = REG_ACTIVE_CHANNELS + 1'b1;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       channel = 1'b0;
    logic                       end_of_block = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_channel;
    logic                       out_end_of_block;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]          cfg_index = '0;
    logic [CFG_DW-1:0]          cfg_data = '0;
    int                         mismatches;
    int                         words_in_flight;
    bit                         hold_request = 1'b0;
    bit                         tx_steady = 1'b0;
    bit                         rx_steady = 1'b0;

    multichannel_comb_filter dut (.*);

    mcf_comb_checker comb_check (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r = $urandom_range(0, 99);
        if (r < 8) return 16'sh7fff;
        if (r < 16) return 16'sh8000;
        if (r < 55) return SAMPLE_W'($urandom_range(0, 4095) - 2048);
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [CFG_DW-1:0] pick_gain();
        case ($urandom_range(0, 8))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'h2000;
            5: return CFG_DW'($urandom_range(0, 3));
            default: return CFG_DW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_delay();
        int r = $urandom_range(0, 99);
        if (r < 50) return CFG_DW'($urandom_range(1, 4));
        if (r < 80) return CFG_DW'($urandom_range(5, 300));
        if (r < 88) return '0;
        if (r < 94) return 16'hffff;
        return CFG_DW'($urandom);
    endfunction

    task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input logic ch,
                             input logic eob);
        int gap;
        in_valid <= 1'b1;
        sample_in <= x;
        channel <= ch;
        end_of_block <= eob;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_filter(input logic fmode, input logic [CFG_DW-1:0] g,
                                  input logic [CFG_DW-1:0] d, input logic [1:0] nch);
        wait_drained();
        write_reg(REG_FILTER_MODE, {15'($urandom), fmode});
        write_reg(REG_GAIN, g);
        write_reg(REG_DELAY_SAMPLES, d);
        write_reg(REG_ACTIVE_CHANNELS, {14'($urandom), nch});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IW'($urandom_range(REG_FIRST_UNUSED, 2**CFG_IW - 1)),
                      CFG_DW'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'sh7fff, 1'b0, 1'b0);
        send_word(16'sh7fff, 1'b0, 1'b1);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sh8000, 1'b1, 1'b1);
        send_word(16'sh7fff, 1'b1, 1'b0);
        send_word(16'sh0001, 1'b0, 1'b0);
        send_word(16'shffff, 1'b1, 1'b1);

        program_filter(MODE_FEEDBACK, 16'h8000, 16'h0000, 2'd0);
        send_word(16'sh4000, 1'b0, 1'b0);
        send_word(16'sh4000, 1'b0, 1'b1);
        send_word(16'sh7fff, 1'b1, 1'b0);
        send_word(16'sh8000, 1'b1, 1'b1);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sh7fff, 1'b0, 1'b0);

        program_filter(MODE_FEEDFORWARD, 16'h7fff, 16'hffff, 2'd3);
        send_word(16'sh7fff, 1'b1, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b1);
        send_word(16'sh1234, 1'b1, 1'b0);
        send_word(16'shedcb, 1'b0, 1'b0);

        // round half up on a tiny gain
        program_filter(MODE_FEEDBACK, 16'h0001, 16'd2, 2'd1);
        send_word(16'sh2000, 1'b0, 1'b0);
        send_word(16'shdfff, 1'b0, 1'b0);
        send_word(16'sh0000, 1'b0, 1'b0);
        send_word(16'sh0000, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            program_filter(1'($urandom), pick_gain(), pick_delay(),
                           ($urandom_range(0, 1) == 0) ? 2'($urandom) : 2'd2);
            tx_steady = (p % 5 == 2);
            rx_steady = (p % 5 == 3);
            if (p == 6) hold_request = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_sample(), 1'($urandom), $urandom_range(0, 7) == 0);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && words_in_flight == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_steady || $urandom_range(0, 99) < 60) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3))
                    @(posedge clk);
            end
        end
    end

    initial begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mcf_pkg.sv
hdl/mcf_delay_mem.sv
hdl/multichannel_comb_filter.sv
tb/sv/mcf_comb_checker.sv
tb/sv/tb_multichannel_comb_filter.sv
